### sv/bpd_pkg.sv
// Package for the binomial prime divisibility block.
// Holds the controller/datapath command and status structs and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package bpd_pkg;

  // Result stream width: divides_flag in bit 0, zero padded to a byte
  localparam int OUT_TDATA_W = 8;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture n, k, p; power q starts at p
    logic init;     // clear remainders and product, restart bit counter
    logic step;     // one bit of both remainders and of the product
    logic advance;  // q takes the finished product q*p
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic p_small;   // p below two
    logic p_over_n;  // p above n, no power to test
    logic last;      // bit counter at its final step
    logic borrow;    // k mod q above n mod q
    logic stop;      // next power exceeds n
  } status_t;

endpackage

### sv/bpd_datapath.sv
// Datapath of the binomial prime divisibility block.
// Bit-serial remainders of n and k by the power q, and the serial product q*p.
// Depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_datapath #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic [VALUE_BITS-1:0] top_value,
  input  logic [VALUE_BITS-1:0] lower_value,
  input  logic [VALUE_BITS-1:0] prime_base,
  input  bpd_pkg::cmd_t         cmd,
  output bpd_pkg::status_t      status
);

  localparam int CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] n_val;
  logic [VALUE_BITS-1:0] k_val;
  logic [VALUE_BITS-1:0] p_val;
  logic [VALUE_BITS-1:0] q;
  logic [VALUE_BITS-1:0] rem_n;
  logic [VALUE_BITS-1:0] rem_k;
  logic [VALUE_BITS-1:0] acc;
  logic                  ovf;
  logic [CW-1:0]         cnt;

  logic [VALUE_BITS:0]   rn_shift;
  logic [VALUE_BITS:0]   rk_shift;
  logic [VALUE_BITS:0]   q_ext;
  logic [VALUE_BITS-1:0] rem_n_next;
  logic [VALUE_BITS-1:0] rem_k_next;
  logic [VALUE_BITS+1:0] acc_sum;
  logic [VALUE_BITS+1:0] addend;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  ovf_next;

  // Restoring division step for both dividends against the same divisor
  always_comb begin
    q_ext    = {1'b0, q};
    rn_shift = {rem_n, n_val[cnt]};
    rk_shift = {rem_k, k_val[cnt]};
    if (rn_shift >= q_ext) begin
      rem_n_next = VALUE_BITS'(rn_shift - q_ext);
    end else begin
      rem_n_next = rn_shift[VALUE_BITS-1:0];
    end
    if (rk_shift >= q_ext) begin
      rem_k_next = VALUE_BITS'(rk_shift - q_ext);
    end else begin
      rem_k_next = rk_shift[VALUE_BITS-1:0];
    end
  end

  // Horner step of q*p, MSB of p first; overflow past the value width is sticky
  always_comb begin
    addend   = p_val[cnt] ? {2'b00, q} : '0;
    acc_sum  = {1'b0, acc, 1'b0} + addend;
    ovf_next = ovf | (acc_sum[VALUE_BITS+1:VALUE_BITS] != 2'b00);
    acc_next = acc_sum[VALUE_BITS-1:0];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_val <= top_value;
      k_val <= lower_value;
      p_val <= prime_base;
      q     <= prime_base;
    end
    if (cmd.advance) begin
      q <= acc;
    end
    if (cmd.init) begin
      rem_n <= '0;
      rem_k <= '0;
      acc   <= '0;
      ovf   <= 1'b0;
      cnt   <= CW'(VALUE_BITS - 1);
    end else if (cmd.step) begin
      rem_n <= rem_n_next;
      rem_k <= rem_k_next;
      acc   <= acc_next;
      ovf   <= ovf_next;
      cnt   <= cnt - 1'b1;
    end
  end

  // Status back to the controller
  always_comb begin
    status.p_small  = (p_val[VALUE_BITS-1:1] == '0);
    status.p_over_n = (p_val > n_val);
    status.last     = (cnt == '0);
    status.borrow   = (rem_k > rem_n);
    status.stop     = ovf | (acc > n_val);
  end

endmodule

### sv/bpd_ctrl.sv
// Controller of the binomial prime divisibility block.
// Sequences load, per-power bit loops and evaluation; holds the result register.
// Depends on bpd_pkg.
`timescale 1ns / 1ps

module bpd_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bpd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [0] divides_flag
  output bpd_pkg::cmd_t                    cmd,
  input  bpd_pkg::status_t                 status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_EVAL,
    S_DONE
  } state_t;

  state_t state;
  logic   res;
  logic   out_flag;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(bpd_pkg::OUT_TDATA_W - 1){1'b0}}, out_flag};

  // Commands decoded from state
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = s_tvalid;
      S_CHECK: cmd.init = 1'b1;
      S_RUN:   cmd.step = 1'b1;
      S_EVAL: begin
        if (!status.borrow && !status.stop) begin
          cmd.init    = 1'b1;
          cmd.advance = 1'b1;
        end
      end
      S_DONE:  cmd = '0;
      default: cmd = '0;
    endcase
  end

  // State, result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      res      <= 1'b0;
      out_flag <= 1'b0;
    end else begin
      // result taken; S_DONE handles the output register itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (status.p_small || status.p_over_n) begin
            res   <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (status.last) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (status.borrow) begin
            res   <= 1'b1;
            state <= S_DONE;
          end else if (status.stop) begin
            res   <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_RUN;
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_flag <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/binomial_prime_divisibility.sv
// Top level of the binomial prime divisibility block (Kummer borrow test).
// Instantiates bpd_ctrl and bpd_datapath; depends on bpd_pkg.
//
//   channel | dir | payload (low bit first)            | handshake
//   s_*     | in  | top_value, lower_value, prime_base | s_tvalid / s_tready
//   m_*     | out | divides_flag                       | m_tvalid / m_tready
//
// One item at a time. An item takes the load and check steps plus, for each power
// of p tested, a pass of the bit-serial remainder and multiply loop and an
// evaluation; p = 2 tests the most powers. The loop works one bit per cycle.
// Synchronous active-high reset clears the controller and the output register.
// A stalled result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module binomial_prime_divisibility #(
  parameter int VALUE_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: top_value, lower_value, prime_base, zero padding
  input  logic [((3*VALUE_BITS+7)/8)*8-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: divides_flag, zero padding
  output logic [bpd_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  bpd_pkg::cmd_t    cmd;
  bpd_pkg::status_t status;

  // Controller
  bpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath
  bpd_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .top_value   (s_tdata[VALUE_BITS-1:0]),
    .lower_value (s_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .prime_base  (s_tdata[3*VALUE_BITS-1:2*VALUE_BITS]),
    .cmd         (cmd),
    .status      (status)
  );

`ifndef SYNTHESIS
  // Busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while previous item still in work");

  // Load, init and step never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.init, cmd.step}))
    else $error("overlapping datapath commands");

  // A power advance always restarts the bit loop
  a_advance_inits: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> cmd.init)
    else $error("power advanced without loop restart");
`endif

endmodule
